// ----- sv/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console character engine package
// Shared types, codes and default sizes for the console engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Cursor step of a tab.
    localparam int TAB_STEP = 8;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Character codes.
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [7:0] BLANK_CHAR = 8'd32;
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    // Action codes of an input beat.
    localparam logic ACTION_PUT  = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ENABLE     = 2'd2;

    localparam logic [3:0] RESET_TEXT_COLOR       = 4'd0;
    localparam logic [2:0] RESET_BACKGROUND_COLOR = 3'd4;
    localparam logic       RESET_BLINK_ENABLE     = 1'b0;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ,
        OP_READ_NONE,
        OP_PRINT,
        OP_TAB,
        OP_LINE_FEED,
        OP_CLEAR,
        OP_BACKSPACE,
        OP_RETURN
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK
    } state_t;

endpackage

`default_nettype wire

// ----- sv/tcce_front.sv -----
// ----------------------------------------------------------------------------
// Console engine front end
// Accepts input beats, classifies them into commands and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_front
    import tcce_pkg::*;
#(
    parameter int CELLS = COLUMNS_DEF * ROWS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    op_t  op_class;

    always_comb begin
        op_class = OP_NOP;
        if (s_data.action == ACTION_READ) begin
            // Out-of-range reads answer zero without touching the screen.
            if (32'(s_data.cell_address) < 32'(CELLS)) begin
                op_class = OP_READ;
            end else begin
                op_class = OP_READ_NONE;
            end
        end else if (s_data.char_code >= PRINT_LO && s_data.char_code <= PRINT_HI) begin
            op_class = OP_PRINT;
        end else begin
            case (s_data.char_code)
                CHAR_TAB: op_class = OP_TAB;
                CHAR_LF:  op_class = OP_LINE_FEED;
                CHAR_FF:  op_class = OP_CLEAR;
                CHAR_BS:  op_class = OP_BACKSPACE;
                CHAR_CR:  op_class = OP_RETURN;
                default:  op_class = OP_NOP;
            endcase
        end
    end

    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_valid_next = cmd_valid_reg && !cmd_ready;
        cmd_next       = cmd_reg;
        if (s_valid && s_ready) begin
            cmd_valid_next         = 1'b1;
            cmd_next.op            = op_class;
            cmd_next.char_code     = s_data.char_code;
            cmd_next.cell_address  = s_data.cell_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

// ----- sv/tcce_queue.sv -----
// ----------------------------------------------------------------------------
// Console engine command queue
// A short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_queue
    import tcce_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tcce_back.sv -----
// ----------------------------------------------------------------------------
// Console engine back end
// Holds cursor and screen memory, executes commands and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_back
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] attr,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire cmd_t       cmd,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'(CELLS - COLUMNS);

    state_t            state_reg;
    state_t            state_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic              wr_pend_reg;
    logic              wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [ADDR_W-1:0] wr_addr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;

    logic [15:0]       mem [CELLS];
    logic [15:0]       rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              emit;
    logic [15:0]       emit_data;
    logic [ADDR_W-1:0] cursor_addr;
    logic              col_inc_ok;
    logic              tab_ok;
    logic              row_inc_ok;
    logic [15:0]       blank_cell;

    assign cursor_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign col_inc_ok  = (COL_W+1)'(col_reg) + (COL_W+1)'(1) < (COL_W+1)'(COLUMNS);
    assign tab_ok      = (COL_W+1)'(col_reg) + (COL_W+1)'(TAB_STEP) < (COL_W+1)'(COLUMNS);
    assign row_inc_ok  = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1) < (ROW_W+1)'(ROWS);
    assign blank_cell  = {attr, BLANK_CHAR};

    // A command is taken only when the result slot is free or being emptied,
    // so the slot is always free when a multi-cycle command finishes.
    assign cmd_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ptr_next       = ptr_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_addr_reg;
        mem_wdata      = rdata_reg;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg;
        emit           = 1'b0;
        emit_data      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    case (cmd.op)
                        OP_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(cmd.cell_address);
                            state_next = ST_READ;
                        end
                        OP_PRINT, OP_LINE_FEED: begin
                            if (cmd.op == OP_PRINT) begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_addr;
                                mem_wdata = {attr, cmd.char_code};
                            end
                            if (cmd.op == OP_PRINT && col_inc_ok) begin
                                col_next = col_reg + COL_W'(1);
                                emit     = 1'b1;
                            end else if (row_inc_ok) begin
                                row_next = row_reg + ROW_W'(1);
                                col_next = '0;
                                emit     = 1'b1;
                            end else begin
                                // Cursor stays on the last row; the screen moves up.
                                col_next   = '0;
                                ptr_next   = ADDR_W'(COLUMNS);
                                state_next = ST_SCROLL;
                            end
                        end
                        OP_TAB: begin
                            if (tab_ok) begin
                                col_next = col_reg + COL_W'(TAB_STEP);
                            end
                            emit = 1'b1;
                        end
                        OP_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_BLANK;
                        end
                        OP_BACKSPACE: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - COL_W'(1);
                            end
                            emit = 1'b1;
                        end
                        OP_RETURN: begin
                            col_next = '0;
                            emit     = 1'b1;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                emit       = 1'b1;
                emit_data  = rdata_reg;
                state_next = ST_IDLE;
            end
            ST_SCROLL: begin
                // Read the cell one row below and write it one row up in the next cycle.
                mem_we       = wr_pend_reg;
                mem_re       = 1'b1;
                mem_raddr    = ptr_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg - ADDR_W'(COLUMNS);
                if (ptr_reg == LAST_CELL) begin
                    ptr_next   = LAST_ROW0;
                    state_next = ST_BLANK;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_BLANK: begin
                if (wr_pend_reg) begin
                    mem_we = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg;
                    mem_wdata = blank_cell;
                    if (ptr_reg == LAST_CELL) begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next      = 1'b1;
            out_next.cell_data  = emit_data;
            out_next.cursor_row = 5'(row_next);
            out_next.cursor_col = 7'(col_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        wr_addr_reg <= wr_addr_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_busy_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("result slot occupied while a command is in progress");

    a_pend_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> (state_reg == ST_SCROLL || state_reg == ST_BLANK))
        else $error("copy write pending outside a scroll");

    a_read_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("read did not finish in one cycle");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_reg) < 32'(ROWS) && 32'(col_reg) < 32'(COLUMNS))
        else $error("cursor left the screen");
`endif

endmodule

`default_nettype wire

// ----- sv/text_console_character_engine_top.sv -----
// ----------------------------------------------------------------------------
// Text console character engine
// A COLUMNS x ROWS text console with cursor, scrolling and cell read-back.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_ is either a put of one character code or a
// read of one screen cell; every input beat yields exactly one result beat
// on m_ with the read cell (zero for a put) and the cursor after the item.
// The cfg_ channel writes text color, background color and blink enable; it
// is always ready and should be written only while the engine is idle.
// A put that writes a cell or moves the cursor passes the command register,
// the queue and the result register; a read also passes the memory's read
// register. One such item completes per cycle while the receiver takes
// results, and a read holds the back end in its read state. A form feed
// sweeps every cell. A scroll copies each row up through the memory's one
// read and one write port and blanks the last row. Input beats keep queueing
// in the front end and the command queue during a sweep until it is full.
// Reset homes the cursor and loads the default colors; the screen is not
// cleared, so a cell should be read only after it was written or blanked.
// When the receiver stalls, the result register holds its beat and the back
// end stops taking commands; the front end stalls once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_character_engine_top
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [3:0] text_color_reg;
    logic [2:0] background_color_reg;
    logic       blink_enable_reg;
    logic [7:0] attr;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;
    assign attr      = {blink_enable_reg, background_color_reg, text_color_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg       <= RESET_TEXT_COLOR;
            background_color_reg <= RESET_BACKGROUND_COLOR;
            blink_enable_reg     <= RESET_BLINK_ENABLE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TEXT_COLOR:       text_color_reg       <= cfg_data[3:0];
                CFG_BACKGROUND_COLOR: background_color_reg <= cfg_data[2:0];
                CFG_BLINK_ENABLE:     blink_enable_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tcce_front #(
        .CELLS (COLUMNS * ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tcce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    tcce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .attr      (attr),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
